FILE: design/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants for the sorted score list.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int unsigned KEY_W         = 64;
  localparam int unsigned SCORE_W       = 16;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned DEPTH_DEF     = 32;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned IN_DATA_W     = 88;
  localparam int unsigned OUT_DATA_W    = 88;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_READOUT = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_DELETED   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_ENTRY     = 3'd4,
    STS_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_CHECK  = 2'd2,
    S_RESULT = 2'd3
  } state_e;

endpackage

FILE: design/sorted_score_list.sv
// ----------------------------------------------------------------------------
// sorted_score_list
// List of (key, score) entries kept in descending score order.
// ----------------------------------------------------------------------------
// A request takes one pass over the stored entries through an entry memory
// with one read and one write port; each entry visited takes a read step and
// then a compare-and-move step. Insert walks from the tail, moving
// lower-scored entries down by one, until it reaches the head or stops on an
// entry with a higher or equal score. Delete walks the whole list, moving the
// entries behind the match up. Readout loads one entry into the output
// register per compare step. Full inserts and empty readouts skip the walk
// and give their one result directly. Unknown request types give no result
// and leave tready high. A stalled output holds the sequencer. Input tready
// is low from request acceptance until its last result has been loaded into
// the output register. Equal scores keep arrival order.
// ----------------------------------------------------------------------------
module sorted_score_list #(
  parameter int unsigned DEPTH     = ssl_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES = ssl_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // req_type[1:0], entry_key[65:2], entry_score[81:66], zero fill
  input  logic [ssl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status[2:0], out_key[66:3], out_score[82:67], zero fill
  output logic [ssl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ssl_pkg::SCORE_W;

  ssl_pkg::state_e  state_q, state_d;
  ssl_pkg::req_e    req_q, req_d;
  ssl_pkg::status_e status_q, status_d;
  logic [KW-1:0]         key_q, key_d;
  logic signed [SW-1:0]  score_q, score_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  found_q, found_d;

  logic                  out_valid_q, out_valid_d;
  ssl_pkg::status_e      out_status_q, out_status_d;
  logic [ssl_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic [SW-1:0]         out_score_q, out_score_d;
  logic                  out_last_q, out_last_d;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KW-1:0]         wr_key;
  logic signed [SW-1:0]  wr_score;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [KW-1:0]         rd_key;
  logic signed [SW-1:0]  rd_score;

  logic                  in_fire;
  logic                  out_free;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         count_m1;
  logic                  score_ge;
  ssl_pkg::req_e         in_req;

  assign in_req   = ssl_pkg::req_e'(s_axis_tdata_i[ssl_pkg::REQ_W-1:0]);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign idx_m1   = idx_q - CW'(1);
  assign count_m1 = count_q - CW'(1);
  assign score_ge = rd_score >= score_q;

  assign s_axis_tready_o = (state_q == ssl_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(ssl_pkg::OUT_DATA_W - ssl_pkg::STATUS_W - ssl_pkg::KEY_W
                              - SW){1'b0}},
                            out_score_q, out_key_q, out_status_q};

  ssl_entry_mem #(
    .DEPTH (DEPTH),
    .KW    (KW)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_score_i (wr_score),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_key_o   (rd_key),
    .rd_score_o (rd_score)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ssl_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_req)
            ssl_pkg::REQ_INSERT:
              state_d = (count_q == CW'(DEPTH)) ? ssl_pkg::S_RESULT : ssl_pkg::S_READ;
            ssl_pkg::REQ_DELETE:
              state_d = ssl_pkg::S_READ;
            ssl_pkg::REQ_READOUT:
              state_d = (count_q == '0) ? ssl_pkg::S_RESULT : ssl_pkg::S_READ;
            default:
              state_d = ssl_pkg::S_IDLE;
          endcase
        end
      end
      ssl_pkg::S_READ: begin
        case (req_q)
          ssl_pkg::REQ_INSERT:
            state_d = (idx_q == '0) ? ssl_pkg::S_RESULT : ssl_pkg::S_CHECK;
          ssl_pkg::REQ_DELETE:
            state_d = (idx_q == count_q) ? ssl_pkg::S_RESULT : ssl_pkg::S_CHECK;
          default:
            state_d = ssl_pkg::S_CHECK;
        endcase
      end
      ssl_pkg::S_CHECK: begin
        case (req_q)
          ssl_pkg::REQ_INSERT:
            state_d = score_ge ? ssl_pkg::S_RESULT : ssl_pkg::S_READ;
          ssl_pkg::REQ_DELETE:
            state_d = ssl_pkg::S_READ;
          default: begin
            if (out_free) begin
              state_d = (idx_q == count_m1) ? ssl_pkg::S_IDLE : ssl_pkg::S_READ;
            end
          end
        endcase
      end
      ssl_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = ssl_pkg::S_IDLE;
        end
      end
      default: state_d = ssl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    status_d     = status_q;
    key_d        = key_q;
    score_d      = score_q;
    idx_d        = idx_q;
    count_d      = count_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_score_d  = out_score_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[AW-1:0];
    wr_key       = key_q;
    wr_score     = score_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q[AW-1:0];

    case (state_q)
      ssl_pkg::S_IDLE: begin
        if (in_fire) begin
          req_d   = in_req;
          key_d   = s_axis_tdata_i[ssl_pkg::REQ_W +: KW];
          score_d = s_axis_tdata_i[ssl_pkg::REQ_W + ssl_pkg::KEY_W +: SW];
          found_d = 1'b0;
          idx_d   = (in_req == ssl_pkg::REQ_INSERT) ? count_q : '0;
          status_d = (in_req == ssl_pkg::REQ_INSERT) ? ssl_pkg::STS_FULL
                                                     : ssl_pkg::STS_EMPTY;
        end
      end
      ssl_pkg::S_READ: begin
        case (req_q)
          ssl_pkg::REQ_INSERT: begin
            if (idx_q == '0) begin
              wr_en    = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = ssl_pkg::STS_INSERTED;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_m1[AW-1:0];
            end
          end
          ssl_pkg::REQ_DELETE: begin
            if (idx_q == count_q) begin
              if (found_q) begin
                count_d  = count_m1;
                status_d = ssl_pkg::STS_DELETED;
              end else begin
                status_d = ssl_pkg::STS_NOT_FOUND;
              end
            end else begin
              rd_en = 1'b1;
            end
          end
          default: rd_en = 1'b1;
        endcase
      end
      ssl_pkg::S_CHECK: begin
        case (req_q)
          ssl_pkg::REQ_INSERT: begin
            wr_en = 1'b1;
            if (score_ge) begin
              count_d  = count_q + CW'(1);
              status_d = ssl_pkg::STS_INSERTED;
            end else begin
              wr_key   = rd_key;
              wr_score = rd_score;
              idx_d    = idx_m1;
            end
          end
          ssl_pkg::REQ_DELETE: begin
            if (found_q) begin
              wr_en    = 1'b1;
              wr_addr  = idx_m1[AW-1:0];
              wr_key   = rd_key;
              wr_score = rd_score;
            end else if (rd_key == key_q) begin
              found_d = 1'b1;
            end
            idx_d = idx_q + CW'(1);
          end
          default: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_status_d = ssl_pkg::STS_ENTRY;
              out_key_d    = ssl_pkg::KEY_W'(rd_key);
              out_score_d  = rd_score;
              out_last_d   = (idx_q == count_m1);
              idx_d        = idx_q + CW'(1);
            end
          end
        endcase
      end
      ssl_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_key_d    = '0;
          out_score_d  = '0;
          out_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssl_pkg::S_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    status_q     <= status_d;
    key_q        <= key_d;
    score_q      <= score_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_score_q  <= out_score_d;
    out_last_q   <= out_last_d;
  end

endmodule

FILE: design/ssl_entry_mem.sv
// ----------------------------------------------------------------------------
// ssl_entry_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssl_entry_mem #(
  parameter int unsigned DEPTH = ssl_pkg::DEPTH_DEF,
  parameter int unsigned KW    = 8 * ssl_pkg::KEY_BYTES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [KW-1:0]                     wr_key_i,
  input  logic signed [ssl_pkg::SCORE_W-1:0] wr_score_i,
  input  logic                              rd_en_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic [KW-1:0]                     rd_key_o,
  output logic signed [ssl_pkg::SCORE_W-1:0] rd_score_o
);

  logic [KW-1:0]                      key_mem   [DEPTH];
  logic [ssl_pkg::SCORE_W-1:0]        score_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]   <= wr_key_i;
      score_mem[wr_addr_i] <= wr_score_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o   <= key_mem[rd_addr_i];
      rd_score_o <= score_mem[rd_addr_i];
    end
  end

endmodule

FILE: verif/score_list_checker.sv
// ----------------------------------------------------------------------------
// score_list_checker
// Watches both stream channels of the sorted score list. Keeps its own copy
// of the list, works out the results of each accepted request and compares
// every accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module score_list_checker
  import ssl_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [IN_DATA_W-1:0]  req_data_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [OUT_DATA_W-1:0] rsp_data_i,
  input  logic                  rsp_last_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  typedef struct {
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               last;
  } list_result_t;

  logic [KEY_W-1:0]          list_keys   [DEPTH];
  logic signed [SCORE_W-1:0] list_scores [DEPTH];
  int unsigned               list_len = 0;
  list_result_t              owed_results [$];
  int unsigned               error_count = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic void owe_result(status_e st, logic [KEY_W-1:0] k,
                                     logic [SCORE_W-1:0] s, logic l);
    list_result_t r;
    r.status = st;
    r.key    = k;
    r.score  = s;
    r.last   = l;
    owed_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [IN_DATA_W-1:0] data);
    logic [REQ_W-1:0]          req;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    int unsigned               pos;
    req   = data[REQ_W-1:0];
    key   = data[REQ_W +: KEY_W] & KEY_MASK;
    score = data[REQ_W+KEY_W +: SCORE_W];
    case (req)
      REQ_INSERT: begin
        if (list_len >= DEPTH) begin
          owe_result(STS_FULL, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < list_len && list_scores[pos] >= score) pos++;
          for (int unsigned i = list_len; i > pos; i--) begin
            list_keys[i]   = list_keys[i-1];
            list_scores[i] = list_scores[i-1];
          end
          list_keys[pos]   = key;
          list_scores[pos] = score;
          list_len++;
          owe_result(STS_INSERTED, '0, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        pos = 0;
        while (pos < list_len && list_keys[pos] != key) pos++;
        if (pos >= list_len) begin
          owe_result(STS_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = pos; i + 1 < list_len; i++) begin
            list_keys[i]   = list_keys[i+1];
            list_scores[i] = list_scores[i+1];
          end
          list_len--;
          owe_result(STS_DELETED, '0, '0, 1'b1);
        end
      end
      REQ_READOUT: begin
        if (list_len == 0) begin
          owe_result(STS_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_len; i++) begin
            owe_result(STS_ENTRY, list_keys[i], list_scores[i], i + 1 == list_len);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        got.status = status_e'(rsp_data_i[STATUS_W-1:0]);
        got.key    = rsp_data_i[STATUS_W +: KEY_W];
        got.score  = rsp_data_i[STATUS_W+KEY_W +: SCORE_W];
        got.last   = rsp_last_i;
        if (owed_results.size() == 0) begin
          error_count++;
          $write("%0t ERROR unexpected result: expected none,", $time);
          $display(" got status %0d key %h score %h last %b",
                   got.status, got.key, got.score, got.last);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.score !== want.score || got.last !== want.last) begin
            error_count++;
            $write("%0t ERROR result: expected status %0d key %h score %h last %b,",
                   $time, want.status, want.key, want.score, want.last);
            $display(" got status %0d key %h score %h last %b",
                     got.status, got.key, got.score, got.last);
          end
        end
      end
      if (req_valid_i && req_ready_i) predict_list_op(req_data_i);
    end
    pending_o <= owed_results.size();
    errors_o  <= error_count;
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted score list: directed inserts, deletes and readouts
// at the field extremes and on ties, then random request mixes including a
// burst that overfills the list, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ssl_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned      PAD_W      = IN_DATA_W - REQ_W - KEY_W - SCORE_W;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  calm     = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  int unsigned           outstanding;
  int unsigned           errors;
  logic [KEY_W-1:0]      key_pool [$];

  sorted_score_list u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  score_list_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid),
    .req_ready_i (s_tready),
    .req_data_i  (s_tdata),
    .rsp_valid_i (m_tvalid),
    .rsp_ready_i (m_tready),
    .rsp_data_i  (m_tdata),
    .rsp_last_i  (m_tlast),
    .errors_o    (errors),
    .pending_o   (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 29);
  end

  initial begin
    #5_000_000;
    $display("sorted_score_list: mismatch");
    $finish;
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                              logic [SCORE_W-1:0] score);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, score, key, req};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [SCORE_W-1:0] random_score();
    case ($urandom_range(0, 3))
      0:       return SCORE_W'($urandom());
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return SCORE_W'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  initial begin
    logic [KEY_W-1:0] k;
    int unsigned      idx;
    int unsigned      roll;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_READOUT, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_UNUSED, '1, '1);
    send_request(REQ_INSERT, '1, 16'h7fff);
    send_request(REQ_INSERT, '0, 16'h8000);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00a1, 16'h0000);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00b2, 16'h0000);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00c3, 16'hffff);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00d4, 16'h7fff);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00e5, 16'h8000);
    send_request(REQ_READOUT, 64'h1234_5678_9abc_def0, 16'h5a5a);
    send_request(REQ_DELETE, 64'h0000_0000_0000_00b2, '0);
    send_request(REQ_DELETE, '1, '0);
    send_request(REQ_DELETE, '0, '1);
    send_request(REQ_DELETE, 64'h8000_0000_0000_0001, '0);
    send_request(REQ_READOUT, '0, '0);
    send_request(REQ_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555);
    send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 16'haaaa);
    send_request(REQ_INSERT, 64'h0000_0000_0000_00a1, 16'h0000);
    send_request(REQ_DELETE, 64'h0000_0000_0000_00a1, '0);
    send_request(REQ_READOUT, '0, '0);

    wait_for_results();

    for (int n = 0; n < 95; n++) begin
      calm <= (n >= 30 && n < 60);
      if (n == 70) begin
        for (int j = 0; j < 34; j++) begin
          k = random_key();
          key_pool.push_back(k);
          send_request(REQ_INSERT, k, random_score());
        end
        send_request(REQ_READOUT, random_key(), random_score());
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        k = random_key();
        key_pool.push_back(k);
        send_request(REQ_INSERT, k, random_score());
      end else if (roll < 75) begin
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, key_pool.size() - 1);
          k   = key_pool[idx];
          key_pool.delete(idx);
        end else begin
          k = random_key();
        end
        send_request(REQ_DELETE, k, random_score());
      end else if (roll < 95) begin
        send_request(REQ_READOUT, random_key(), random_score());
      end else begin
        send_request(REQ_UNUSED, random_key(), random_score());
      end
    end

    calm <= 1'b0;
    wait_for_results();
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("sorted_score_list: match");
    end else begin
      $display("sorted_score_list: mismatch");
    end
    $finish;
  end

endmodule
